>>> hdl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is switched off while reset is high.
`define GPD_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("gait phase detector check failed");

// Clocked property that is also checked around reset.
`define GPD_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("gait phase detector reset check failed");

`endif

>>> hdl/gpd_pkg.sv
package gpd_pkg;

   // Sizes.
   localparam int NUM_SLOTS_DEFAULT = 8;
   localparam int QUEUE_DEPTH = 2;
   localparam int OUT_DEPTH = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 48;
   localparam int MASK_BITS_PER_SLOT = 6;

   // Register reset values.
   localparam logic [15:0] STANCE_LOAD_MIN_RESET = 16'd410;
   localparam logic [15:0] SWING_LOAD_MAX_RESET = 16'd410;
   localparam logic signed [15:0] LANDING_RATIO_RESET = 16'sd0;
   localparam logic signed [15:0] LATE_STANCE_RATIO_RESET = 16'sd0;
   localparam logic signed [15:0] LIFTOFF_RATIO_RESET = -16'sd4096;
   localparam logic [15:0] LEG_LEN_RESET = 16'd4096;
   localparam logic [47:0] SLOT_PHASE_MASKS_RESET = 48'd0;
   localparam logic [7:0] SLOT_LEG_SELECT_RESET = 8'd0;

   // Register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STANCE_LOAD_MIN,
      CSR_SWING_LOAD_MAX,
      CSR_LANDING_RATIO,
      CSR_LATE_STANCE_RATIO,
      CSR_LIFTOFF_RATIO,
      CSR_LEG_LEN,
      CSR_SLOT_PHASE_MASKS,
      CSR_SLOT_LEG_SELECT
   } csr_index_type;

   // Gait phases.
   typedef enum logic [2:0] {
      PH_UNKNOWN,
      PH_EARLY,
      PH_LATE,
      PH_LIFTOFF,
      PH_SWING,
      PH_LANDING
   } phase_type;

   // Input word.
   typedef struct packed {
      logic               new_step;
      logic [31:0]        tick_time;
      logic [15:0]        left_load;
      logic [15:0]        right_load;
      logic signed [15:0] left_foot_x;
      logic signed [15:0] left_base_x;
      logic signed [15:0] right_foot_x;
      logic signed [15:0] right_base_x;
   } req_type;

   // Result word.
   typedef struct packed {
      logic [2:0]  slot_index;
      logic        slot_active;
      logic [31:0] slot_elapsed;
      logic [2:0]  left_phase;
      logic [2:0]  right_phase;
      logic        last_slot;
   } rsp_type;

   // Registers seen by the classifier.
   typedef struct packed {
      logic [15:0]        stance_load_min;
      logic [15:0]        swing_load_max;
      logic signed [15:0] landing_ratio;
      logic signed [15:0] late_stance_ratio;
      logic signed [15:0] liftoff_ratio;
      logic [15:0]        leg_len;
   } cfg_front_type;

   // Registers seen by the slot sequencer.
   typedef struct packed {
      logic [47:0] slot_phase_masks;
      logic [7:0]  slot_leg_select;
   } cfg_back_type;

   // Condition flags of one leg for one tick.
   typedef struct packed {
      logic stance;
      logic swing;
      logic late;
      logic lift;
      logic land;
      logic behind;   // other leg in stance and this leg's offset smaller
      logic ahead;    // this leg's offset larger than the other's
   } leg_view_type;

   // Classified word passed from the front to the back.
   typedef struct packed {
      logic         new_step;
      logic [31:0]  tick_time;
      leg_view_type left_view;
      leg_view_type right_view;
   } cls_type;

   // One step of a leg's phase machine.
   function automatic phase_type next_phase(phase_type ph, leg_view_type me);
      phase_type nxt;
      nxt = ph;
      unique case (ph)
         PH_UNKNOWN: begin
            if (me.stance) begin
               if (me.behind) nxt = PH_LIFTOFF;
               else if (me.late) nxt = PH_LATE;
               else nxt = PH_EARLY;
            end else begin
               nxt = me.land ? PH_LANDING : PH_SWING;
            end
         end
         PH_EARLY: begin
            if (me.behind) nxt = PH_LIFTOFF;
            else if (me.late) nxt = PH_LATE;
         end
         PH_LATE: begin
            if (me.behind || me.lift) nxt = PH_LIFTOFF;
         end
         PH_LIFTOFF: begin
            if (me.swing) nxt = PH_SWING;
         end
         PH_SWING: begin
            if (me.stance && me.ahead) nxt = PH_EARLY;
            else if (!me.stance && me.land) nxt = PH_LANDING;
         end
         PH_LANDING: begin
            if (me.stance) nxt = PH_EARLY;
         end
         default: nxt = ph;
      endcase
      return nxt;
   endfunction

endpackage

>>> hdl/gpd_fifo.sv
module gpd_fifo #(
   parameter type item_type = logic,
   parameter int  DEPTH = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output item_type pop_item,
   output logic     empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   item_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   // Status and pointer updates.
   always_comb begin
      full      = (count_ff == (PTR_W + 1)'(DEPTH));
      empty     = (count_ff == '0);
      do_push   = push && !full;
      do_pop    = pop && !empty;
      pop_item  = mem_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_item;
   end

endmodule

>>> hdl/gpd_front.sv
module gpd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  gpd_pkg::cfg_front_type cfg,
   input  logic                  req_push,
   input  gpd_pkg::req_type      req_word,
   output logic                  req_full,
   output logic                  q_push,
   output gpd_pkg::cls_type      q_item,
   input  logic                  q_full
);

   import gpd_pkg::*;

   logic                valid_a_ff, valid_a_in;
   req_type             item_a_ff, item_a_in;
   logic signed [32:0]  land_thr_ff, land_thr_in;
   logic signed [32:0]  late_thr_ff, late_thr_in;
   logic signed [32:0]  lift_thr_ff, lift_thr_in;
   logic signed [16:0]  len_s;
   logic signed [16:0]  left_off;
   logic signed [16:0]  right_off;
   logic                accept;
   leg_view_type        left_v;
   leg_view_type        right_v;

   // Load and offset threshold flags of one leg against the scaled ratios.
   function automatic leg_view_type view_leg(
      logic [15:0]        load,
      logic signed [16:0] off,
      cfg_front_type      c,
      logic signed [32:0] land_thr,
      logic signed [32:0] late_thr,
      logic signed [32:0] lift_thr
   );
      leg_view_type       v;
      logic signed [33:0] scaled;
      scaled   = {{5{off[16]}}, off, 12'b0};
      v        = '0;
      v.stance = load > c.stance_load_min;
      v.swing  = load <= c.swing_load_max;
      v.late   = scaled < $signed({late_thr[32], late_thr});
      v.lift   = scaled < $signed({lift_thr[32], lift_thr});
      v.land   = scaled > $signed({land_thr[32], land_thr});
      return v;
   endfunction

   // Ratio thresholds scaled by leg length, one multiplier each.
   always_comb begin
      len_s       = $signed({1'b0, cfg.leg_len});
      land_thr_in = 33'(len_s * cfg.landing_ratio);
      late_thr_in = 33'(len_s * cfg.late_stance_ratio);
      lift_thr_in = 33'(len_s * cfg.liftoff_ratio);
   end

   always_ff @(posedge clock) begin
      land_thr_ff <= land_thr_in;
      late_thr_ff <= late_thr_in;
      lift_thr_ff <= lift_thr_in;
   end

   // Input stage: holds one word until the queue takes it.
   always_comb begin
      q_push     = valid_a_ff && !q_full;
      req_full   = valid_a_ff && q_full;
      accept     = req_push && !req_full;
      valid_a_in = accept ? 1'b1 : (q_push ? 1'b0 : valid_a_ff);
      item_a_in  = accept ? req_word : item_a_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_a_ff <= 1'b0;
      else valid_a_ff <= valid_a_in;
   end

   always_ff @(posedge clock) begin
      item_a_ff <= item_a_in;
   end

   // Classify both legs; each leg also looks at the other.
   always_comb begin
      left_off  = $signed({item_a_ff.left_foot_x[15], item_a_ff.left_foot_x})
                - $signed({item_a_ff.left_base_x[15], item_a_ff.left_base_x});
      right_off = $signed({item_a_ff.right_foot_x[15], item_a_ff.right_foot_x})
                - $signed({item_a_ff.right_base_x[15], item_a_ff.right_base_x});
      left_v  = view_leg(item_a_ff.left_load, left_off, cfg,
                         land_thr_ff, late_thr_ff, lift_thr_ff);
      right_v = view_leg(item_a_ff.right_load, right_off, cfg,
                         land_thr_ff, late_thr_ff, lift_thr_ff);
      left_v.behind  = right_v.stance && (left_off < right_off);
      left_v.ahead   = left_off > right_off;
      right_v.behind = left_v.stance && (right_off < left_off);
      right_v.ahead  = right_off > left_off;
      q_item.new_step   = item_a_ff.new_step;
      q_item.tick_time  = item_a_ff.tick_time;
      q_item.left_view  = left_v;
      q_item.right_view = right_v;
   end

endmodule

>>> hdl/gpd_back.sv
module gpd_back #(
   parameter int NUM_SLOTS = gpd_pkg::NUM_SLOTS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  gpd_pkg::cfg_back_type cfg,
   input  logic                 q_empty,
   input  gpd_pkg::cls_type     q_item,
   output logic                 q_pop,
   input  logic                 out_full,
   output logic                 out_push,
   output gpd_pkg::rsp_type     out_item
);

   import gpd_pkg::*;

   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   logic [SLOT_W-1:0] cnt_ff, cnt_in;
   phase_type         left_ph_ff, left_ph_in;
   phase_type         right_ph_ff, right_ph_in;
   logic              act_ff [NUM_SLOTS];
   logic [31:0]       since_ff [NUM_SLOTS];
   logic              act_in;
   logic [31:0]       since_in;
   logic              run;
   logic              first;
   logic              last;
   logic              upd_phase;
   phase_type         left_next;
   phase_type         right_next;
   phase_type         left_cur;
   phase_type         right_cur;
   phase_type         ph;
   logic [MASK_BITS_PER_SLOT-1:0] slot_mask;
   logic [7:0]        mask_ext;
   logic              act_new;
   logic              changed;

   // Phase machines: next state.
   always_comb begin
      left_next  = next_phase(left_ph_ff, q_item.left_view);
      right_next = next_phase(right_ph_ff, q_item.right_view);
   end

   // Slot sequencer: one slot of the head word per cycle while the queue holds a word and the result queue is not full.
   always_comb begin
      run       = !q_empty && !out_full;
      first     = (cnt_ff == '0);
      last      = (cnt_ff == SLOT_W'(NUM_SLOTS - 1));
      upd_phase = first && q_item.new_step;
      left_cur  = upd_phase ? left_next : left_ph_ff;
      right_cur = upd_phase ? right_next : right_ph_ff;
      ph        = cfg.slot_leg_select[cnt_ff] ? right_cur : left_cur;
      slot_mask = cfg.slot_phase_masks[MASK_BITS_PER_SLOT * cnt_ff +: MASK_BITS_PER_SLOT];
      mask_ext  = {2'b00, slot_mask};
      act_new   = mask_ext[ph];
      changed   = q_item.new_step && (act_new != act_ff[cnt_ff]);
      act_in    = changed ? act_new : act_ff[cnt_ff];
      since_in  = changed ? q_item.tick_time : since_ff[cnt_ff];
      q_pop     = run && last;
      out_push  = run;
      cnt_in    = run ? (last ? '0 : cnt_ff + 1'b1) : cnt_ff;
      left_ph_in  = (run && upd_phase) ? left_next : left_ph_ff;
      right_ph_in = (run && upd_phase) ? right_next : right_ph_ff;
   end

   // Result word for the current slot.
   always_comb begin
      out_item.slot_index   = 3'(cnt_ff);
      out_item.slot_active  = act_in;
      out_item.slot_elapsed = q_item.tick_time - since_in;
      out_item.left_phase   = left_cur;
      out_item.right_phase  = right_cur;
      out_item.last_slot    = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         left_ph_ff  <= PH_UNKNOWN;
         right_ph_ff <= PH_UNKNOWN;
         for (int k = 0; k < NUM_SLOTS; k++) begin
            act_ff[k]   <= 1'b0;
            since_ff[k] <= '0;
         end
      end else begin
         cnt_ff      <= cnt_in;
         left_ph_ff  <= left_ph_in;
         right_ph_ff <= right_ph_in;
         if (run) begin
            act_ff[cnt_ff]   <= act_in;
            since_ff[cnt_ff] <= since_in;
         end
      end
   end

endmodule

>>> hdl/gait_phase_detector.sv
// Gait phase detector.
// Input channel: a word on req_word is taken at a clock edge with req_push
// high and req_full low. Each word is one control tick with both legs' loads
// and foot and base positions; new_step set moves the two phase machines.
// Result channel: queue style. While rsp_empty is low the oldest result is on
// rsp_word; rsp_pop high takes it. Each tick gives NUM_SLOTS results, slot 0
// first, last_slot set on the final one.
// Configuration: csr_we writes csr_wdata to register csr_index at the edge;
// write only while no tick is in flight.
// Path: a taken word waits in the input stage, is classified into the tick
// queue, and each of its results is written into the result queue.
// Throughput: the slot sequencer forms one result per cycle while the tick
// queue holds a word and the result queue is not full. An input stage and a
// two-word queue let up to two further ticks wait while the sequencer works.
// Reset: registers take their reset values, both legs go to the unknown
// phase, all slots inactive with change time zero, all queues empty.
// Stall: if rsp_pop stays low the result queue fills, the sequencer holds,
// the tick queue fills and req_full rises; nothing is lost.
module gait_phase_detector #(
   parameter int NUM_SLOTS = gpd_pkg::NUM_SLOTS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   input  gpd_pkg::req_type                   req_word,
   output logic                               req_full,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output gpd_pkg::rsp_type                   rsp_word,
   input  logic                               csr_we,
   input  logic [gpd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [gpd_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   import gpd_pkg::*;

   cfg_front_type cfg_front_ff, cfg_front_in;
   cfg_back_type  cfg_back_ff, cfg_back_in;
   logic          q_push;
   cls_type       q_push_item;
   logic          q_full;
   logic          q_pop;
   cls_type       q_pop_item;
   logic          q_empty;
   logic          out_push;
   rsp_type       out_item;
   logic          out_full;

   // Register file writes.
   always_comb begin
      cfg_front_in = cfg_front_ff;
      cfg_back_in  = cfg_back_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_STANCE_LOAD_MIN:   cfg_front_in.stance_load_min   = csr_wdata[15:0];
            CSR_SWING_LOAD_MAX:    cfg_front_in.swing_load_max    = csr_wdata[15:0];
            CSR_LANDING_RATIO:     cfg_front_in.landing_ratio     = csr_wdata[15:0];
            CSR_LATE_STANCE_RATIO: cfg_front_in.late_stance_ratio = csr_wdata[15:0];
            CSR_LIFTOFF_RATIO:     cfg_front_in.liftoff_ratio     = csr_wdata[15:0];
            CSR_LEG_LEN:           cfg_front_in.leg_len           = csr_wdata[15:0];
            CSR_SLOT_PHASE_MASKS:  cfg_back_in.slot_phase_masks   = csr_wdata[47:0];
            CSR_SLOT_LEG_SELECT:   cfg_back_in.slot_leg_select    = csr_wdata[7:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_front_ff.stance_load_min   <= STANCE_LOAD_MIN_RESET;
         cfg_front_ff.swing_load_max    <= SWING_LOAD_MAX_RESET;
         cfg_front_ff.landing_ratio     <= LANDING_RATIO_RESET;
         cfg_front_ff.late_stance_ratio <= LATE_STANCE_RATIO_RESET;
         cfg_front_ff.liftoff_ratio     <= LIFTOFF_RATIO_RESET;
         cfg_front_ff.leg_len           <= LEG_LEN_RESET;
         cfg_back_ff.slot_phase_masks   <= SLOT_PHASE_MASKS_RESET;
         cfg_back_ff.slot_leg_select    <= SLOT_LEG_SELECT_RESET;
      end else begin
         cfg_front_ff <= cfg_front_in;
         cfg_back_ff  <= cfg_back_in;
      end
   end

   // Front: takes ticks and classifies both legs.
   gpd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_front_ff),
      .req_push (req_push),
      .req_word (req_word),
      .req_full (req_full),
      .q_push   (q_push),
      .q_item   (q_push_item),
      .q_full   (q_full)
   );

   // Queue of classified ticks.
   gpd_fifo #(
      .item_type (cls_type),
      .DEPTH     (QUEUE_DEPTH)
   ) u_tick_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (q_pop_item),
      .empty     (q_empty)
   );

   // Back: phase machines and slot sequencer.
   gpd_back #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_back_ff),
      .q_empty  (q_empty),
      .q_item   (q_pop_item),
      .q_pop    (q_pop),
      .out_full (out_full),
      .out_push (out_push),
      .out_item (out_item)
   );

   // Result queue toward the receiver.
   gpd_fifo #(
      .item_type (rsp_type),
      .DEPTH     (OUT_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_item (out_item),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_item  (rsp_word),
      .empty     (rsp_empty)
   );

endmodule

>>> hdl/gpd_checker.sv
`include "assert_macros.svh"

module gpd_checker #(
   parameter int NUM_SLOTS = gpd_pkg::NUM_SLOTS_DEFAULT
) (
   input logic             clock,
   input logic             reset,
   input logic             req_full,
   input logic             rsp_empty,
   input logic             rsp_pop,
   input gpd_pkg::rsp_type rsp_word
);

   import gpd_pkg::*;

   // After a reset cycle both queues are open and empty.
   `GPD_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> (!req_full && rsp_empty))

   // The last-slot flag marks exactly the highest slot.
   `GPD_ASSERT(a_last_marks_top, clock, reset,
      !rsp_empty |-> (rsp_word.last_slot == (rsp_word.slot_index == 3'(NUM_SLOTS - 1))))

   // After the last word of a tick the next tick starts at slot zero.
   `GPD_ASSERT(a_tick_restarts, clock, reset,
      (!rsp_empty && rsp_pop && rsp_word.last_slot) |=> (rsp_empty || rsp_word.slot_index == 3'd0))

   // Within a tick the slots follow one another.
   `GPD_ASSERT(a_slot_order, clock, reset,
      (!rsp_empty && rsp_pop && !rsp_word.last_slot) |=>
         (rsp_empty || rsp_word.slot_index == $past(rsp_word.slot_index) + 3'd1))

   // A waiting word stays put until it is taken.
   `GPD_ASSERT(a_rsp_hold, clock, reset,
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_word)))

endmodule

bind gait_phase_detector gpd_checker #(
   .NUM_SLOTS (NUM_SLOTS)
) u_gpd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_word  (rsp_word)
);

>>> bench/tb_gait_phase_detector.sv
module tb_gait_phase_detector;
   import gpd_pkg::*;

   localparam int SLOTS = 8;
   localparam int CYCLE_LIMIT = 500000;
   localparam int RANDOM_PHASES = 5;
   localparam int TICKS_PER_PHASE = 40;

   // One step of the directed plan: a register write or a tick word.
   typedef struct {
      bit            csr;
      csr_index_type idx;
      logic [47:0]   data;
      req_type       word;
      bit            typed;
      phase_type     exp_left;
      phase_type     exp_right;
      logic [7:0]    exp_active;
      logic [31:0]   exp_elapsed;
   } plan_row_type;

   // Condition flags of one leg on one tick.
   typedef struct {
      logic signed [16:0] off;
      bit                 stance;
      bit                 swing;
      bit                 late;
      bit                 lift;
      bit                 land;
   } leg_reading_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   req_type     req_word = '0;
   logic        req_full;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   rsp_type     rsp_word;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [47:0] csr_wdata = '0;

   // Register mirror.
   logic [15:0]        cfg_stance_load_min = 16'd410;
   logic [15:0]        cfg_swing_load_max = 16'd410;
   logic signed [15:0] cfg_landing_ratio = 16'sd0;
   logic signed [15:0] cfg_late_ratio = 16'sd0;
   logic signed [15:0] cfg_liftoff_ratio = -16'sd4096;
   logic [15:0]        cfg_leg_len = 16'd4096;
   logic [47:0]        slot_masks = '0;
   logic [7:0]         slot_pick_right = '0;

   // Gait and slot state as the block should hold it.
   phase_type   left_gait = PH_UNKNOWN;
   phase_type   right_gait = PH_UNKNOWN;
   logic [7:0]  slot_on = '0;
   logic [31:0] slot_since [SLOTS];

   rsp_type      slot_reports_due [$];
   plan_row_type plan [$];
   int           error_count = 0;
   int           cycle_count = 0;
   int           burst_left = 0;
   logic [5:0]   pop_beat = '0;
   logic [31:0]  pop_pattern = '1;

   gait_phase_detector uut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_word  (req_word),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Offset and threshold flags of one leg; products kept exact at Q51.12.
   function automatic leg_reading_type judge_leg(input logic [15:0] load,
                                                 input logic signed [15:0] foot,
                                                 input logic signed [15:0] base);
      leg_reading_type r;
      longint scaled;
      longint len;
      r.off = {foot[15], foot} - {base[15], base};
      scaled = longint'(r.off) * 4096;
      len = longint'({1'b0, cfg_leg_len});
      r.stance = load > cfg_stance_load_min;
      r.swing = load <= cfg_swing_load_max;
      r.late = scaled < len * longint'(cfg_late_ratio);
      r.lift = scaled < len * longint'(cfg_liftoff_ratio);
      r.land = scaled > len * longint'(cfg_landing_ratio);
      return r;
   endfunction

   // Next phase of one leg, given its own flags and the other leg's.
   function automatic phase_type step_leg(input phase_type ph, input leg_reading_type me,
                                          input leg_reading_type other);
      logic behind;
      behind = other.stance && (me.off < other.off);
      case (ph)
         PH_UNKNOWN: begin
            if (!me.stance) begin
               if (me.land) return PH_LANDING;
               return PH_SWING;
            end
            if (behind) return PH_LIFTOFF;
            if (me.late) return PH_LATE;
            return PH_EARLY;
         end
         PH_EARLY: begin
            if (behind) return PH_LIFTOFF;
            if (me.late) return PH_LATE;
         end
         PH_LATE: begin
            if (behind || me.lift) return PH_LIFTOFF;
         end
         PH_LIFTOFF: begin
            if (me.swing) return PH_SWING;
         end
         PH_SWING: begin
            if (me.stance && me.off > other.off) return PH_EARLY;
            if (!me.stance && me.land) return PH_LANDING;
         end
         PH_LANDING: begin
            if (me.stance) return PH_EARLY;
         end
         default: ;
      endcase
      return ph;
   endfunction

   // Moves both legs and the slots for one tick and forms its slot reports.
   function automatic void predict_gait_tick(input req_type w, output rsp_type res [SLOTS]);
      leg_reading_type lv;
      leg_reading_type rv;
      phase_type       ph;
      logic            hit;
      if (w.new_step) begin
         lv = judge_leg(w.left_load, w.left_foot_x, w.left_base_x);
         rv = judge_leg(w.right_load, w.right_foot_x, w.right_base_x);
         left_gait = step_leg(left_gait, lv, rv);
         right_gait = step_leg(right_gait, rv, lv);
         for (int k = 0; k < SLOTS; k++) begin
            ph = slot_pick_right[k] ? right_gait : left_gait;
            hit = slot_masks[6 * k + int'(ph)];
            if (hit != slot_on[k]) begin
               slot_on[k] = hit;
               slot_since[k] = w.tick_time;
            end
         end
      end
      for (int k = 0; k < SLOTS; k++) begin
         res[k].slot_index = 3'(k);
         res[k].slot_active = slot_on[k];
         res[k].slot_elapsed = w.tick_time - slot_since[k];
         res[k].left_phase = left_gait;
         res[k].right_phase = right_gait;
         res[k].last_slot = (k == SLOTS - 1);
      end
   endfunction

   function automatic plan_row_type tick_row(input logic ns, input logic [31:0] t,
                                             input logic [15:0] ll, input logic [15:0] rl,
                                             input logic signed [15:0] lf,
                                             input logic signed [15:0] lb,
                                             input logic signed [15:0] rf,
                                             input logic signed [15:0] rb);
      plan_row_type r;
      r.csr = 1'b0;
      r.idx = CSR_STANCE_LOAD_MIN;
      r.data = '0;
      r.typed = 1'b0;
      r.exp_left = PH_UNKNOWN;
      r.exp_right = PH_UNKNOWN;
      r.exp_active = '0;
      r.exp_elapsed = '0;
      r.word.new_step = ns;
      r.word.tick_time = t;
      r.word.left_load = ll;
      r.word.right_load = rl;
      r.word.left_foot_x = lf;
      r.word.left_base_x = lb;
      r.word.right_foot_x = rf;
      r.word.right_base_x = rb;
      return r;
   endfunction

   // Attaches results that are plain to see to a tick row.
   function automatic plan_row_type with_result(input plan_row_type r, input phase_type lp,
                                                input phase_type rp, input logic [7:0] act,
                                                input logic [31:0] elapsed);
      r.typed = 1'b1;
      r.exp_left = lp;
      r.exp_right = rp;
      r.exp_active = act;
      r.exp_elapsed = elapsed;
      return r;
   endfunction

   function automatic plan_row_type reg_row(input csr_index_type idx,
                                            input logic [47:0] data);
      plan_row_type r;
      r = tick_row(1'b0, '0, '0, '0, '0, '0, '0, '0);
      r.csr = 1'b1;
      r.idx = idx;
      r.data = data;
      return r;
   endfunction

   // Appends one row to the directed plan.
   function automatic void add_row(input plan_row_type r);
      plan.insert(plan.size(), r);
   endfunction

   function automatic logic [15:0] pick_load_level();
      case ($urandom_range(0, 7))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'($urandom);
         default: return 16'($urandom_range(0, 8192));
      endcase
   endfunction

   function automatic logic [15:0] pick_ratio();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($urandom);
         default: return 16'($urandom_range(0, 16384) - 8192);
      endcase
   endfunction

   // Load that falls on the stance side or the swing side of the thresholds.
   function automatic logic [15:0] load_for(input bit on);
      int lo;
      if (on) begin
         lo = int'(cfg_stance_load_min) + 1;
         if (lo > 65535) lo = 65535;
         return 16'($urandom_range(lo, 65535));
      end
      return 16'($urandom_range(0, int'(cfg_swing_load_max)));
   endfunction

   // Triangle stride: the foot sweeps back during stance and forward in swing.
   function automatic int stride_offset(input int g, input int half, input int amp);
      int jitter;
      jitter = int'($urandom_range(0, 200)) - 100;
      if (g < half) return amp - (2 * amp * g) / half + jitter;
      return -amp + (2 * amp * (g - half)) / half + jitter;
   endfunction

   // Splits an offset into a foot and a base position that both fit 16 bits.
   function automatic void place_leg(input int off, output logic signed [15:0] foot,
                                     output logic signed [15:0] base);
      int lo;
      int hi;
      int b;
      if (off > 32767) off = 32767;
      if (off < -32767) off = -32767;
      lo = (off > 0) ? -32768 : -32768 - off;
      hi = (off > 0) ? 32767 - off : 32767;
      b = lo + int'($urandom_range(0, hi - lo));
      base = 16'(b);
      foot = 16'(b + off);
   endfunction

   // Sends one tick word in bursts with random gaps, then queues its reports.
   task automatic send_tick(input plan_row_type row);
      rsp_type res [SLOTS];
      if (burst_left == 0) begin
         @(negedge clock);
         req_push <= 1'b0;
         repeat ($urandom_range(0, 10)) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
      end
      @(negedge clock);
      req_push <= 1'b1;
      req_word <= row.word;
      do @(posedge clock); while (req_full);
      burst_left--;
      predict_gait_tick(row.word, res);
      for (int k = 0; k < SLOTS; k++) begin
         if (row.typed) begin
            res[k].slot_active = row.exp_active[k];
            res[k].slot_elapsed = row.exp_elapsed;
            res[k].left_phase = row.exp_left;
            res[k].right_phase = row.exp_right;
         end
         slot_reports_due.insert(slot_reports_due.size(), res[k]);
      end
   endtask

   // Stops sending and waits until every queued report has come out.
   task automatic wait_for_quiet();
      @(negedge clock);
      req_push <= 1'b0;
      burst_left = 0;
      while (slot_reports_due.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [47:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_STANCE_LOAD_MIN:   cfg_stance_load_min = value[15:0];
         CSR_SWING_LOAD_MAX:    cfg_swing_load_max = value[15:0];
         CSR_LANDING_RATIO:     cfg_landing_ratio = value[15:0];
         CSR_LATE_STANCE_RATIO: cfg_late_ratio = value[15:0];
         CSR_LIFTOFF_RATIO:     cfg_liftoff_ratio = value[15:0];
         CSR_LEG_LEN:           cfg_leg_len = value[15:0];
         CSR_SLOT_PHASE_MASKS:  slot_masks = value;
         CSR_SLOT_LEG_SELECT:   slot_pick_right = value[7:0];
         default: ;
      endcase
   endtask

   task automatic flag_mismatch(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      error_count++;
      if (error_count <= 10) begin
         $display("slot report mismatch on %s: expected %0h, got %0h", field, want, got);
      end
   endtask

   // The receiver takes a new stall pattern each time pop_beat wraps.
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         pop_beat <= pop_beat + 6'd1;
         if (pop_beat == 6'd63) begin
            case ($urandom_range(0, 3))
               0: pop_pattern <= '1;
               1: pop_pattern <= $urandom & $urandom;
               default: pop_pattern <= $urandom;
            endcase
         end
         rsp_pop <= pop_pattern[pop_beat[4:0]];
      end
   end

   // Every word taken off the result side is checked against the oldest report due.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (slot_reports_due.size() == 0) begin
            error_count++;
            if (error_count <= 10) begin
               $display("slot report for slot %0d with none due", rsp_word.slot_index);
            end
         end else begin
            want = slot_reports_due.pop_front();
            if (rsp_word.slot_index !== want.slot_index)
               flag_mismatch("slot_index", want.slot_index, rsp_word.slot_index);
            if (rsp_word.slot_active !== want.slot_active)
               flag_mismatch("slot_active", want.slot_active, rsp_word.slot_active);
            if (rsp_word.slot_elapsed !== want.slot_elapsed)
               flag_mismatch("slot_elapsed", want.slot_elapsed, rsp_word.slot_elapsed);
            if (rsp_word.left_phase !== want.left_phase)
               flag_mismatch("left_phase", want.left_phase, rsp_word.left_phase);
            if (rsp_word.right_phase !== want.right_phase)
               flag_mismatch("right_phase", want.right_phase, rsp_word.right_phase);
            if (rsp_word.last_slot !== want.last_slot)
               flag_mismatch("last_slot", want.last_slot, rsp_word.last_slot);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_gait_phase_detector: done, errors");
         $finish;
      end
   end

   initial begin
      int period;
      int half;
      int amp;
      int g;
      logic [31:0] now_t;
      logic signed [15:0] lf;
      logic signed [15:0] lb;
      logic signed [15:0] rf;
      logic signed [15:0] rb;

      foreach (slot_since[k]) slot_since[k] = '0;

      // While the masks are all zero every slot stays inactive, so the elapsed
      // time of each report is just the tick time.
      add_row(with_result(tick_row(1'b0, 32'd100, '0, '0, '0, '0, '0, '0),
                          PH_UNKNOWN, PH_UNKNOWN, 8'h00, 32'd100));
      add_row(with_result(tick_row(1'b1, 32'd0, '0, '0, '0, '0, '0, '0),
                          PH_SWING, PH_SWING, 8'h00, 32'd0));
      add_row(with_result(tick_row(1'b1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                                   16'sd32767, 16'sh8000, 16'sh8000, 16'sd32767),
                          PH_EARLY, PH_SWING, 8'h00, 32'hFFFF_FFFF));
      add_row(with_result(tick_row(1'b1, 32'd10, 16'hFFFF, '0,
                                   16'sh8000, 16'sd32767, '0, '0),
                          PH_LATE, PH_SWING, 8'h00, 32'd10));
      add_row(with_result(tick_row(1'b1, 32'd20, 16'hFFFF, 16'd411,
                                   -16'sd8192, '0, 16'sd4096, '0),
                          PH_LIFTOFF, PH_EARLY, 8'h00, 32'd20));
      add_row(with_result(tick_row(1'b1, 32'd30, 16'd410, 16'hFFFF, '0, '0, '0, '0),
                          PH_SWING, PH_EARLY, 8'h00, 32'd30));
      add_row(with_result(tick_row(1'b1, 32'd40, '0, 16'hFFFF,
                                   16'sd1, '0, -16'sd1, '0),
                          PH_LANDING, PH_LATE, 8'h00, 32'd40));
      add_row(with_result(tick_row(1'b1, 32'd50, 16'd411, 16'hFFFF,
                                   16'sd4096, '0, -16'sd4097, '0),
                          PH_EARLY, PH_LIFTOFF, 8'h00, 32'd50));
      // Without a new step the phases hold whatever the loads say.
      add_row(with_result(tick_row(1'b0, 32'd60, 16'hFFFF, 16'hFFFF,
                                   16'sd32767, 16'sh8000, 16'sd32767, 16'sh8000),
                          PH_EARLY, PH_LIFTOFF, 8'h00, 32'd60));
      // Every slot becomes active, half of them following the right leg.
      add_row(reg_row(CSR_SLOT_PHASE_MASKS, 48'hFFFF_FFFF_FFFF));
      add_row(reg_row(CSR_SLOT_LEG_SELECT, 48'hA5));
      add_row(tick_row(1'b1, 32'd70, '0, '0, '0, '0, '0, '0));
      // Sparse masks; slot 0 also has the unknown-phase bit set.
      add_row(reg_row(CSR_SLOT_PHASE_MASKS, 48'h1248_9124_4891));
      add_row(tick_row(1'b1, 32'd80, 16'hFFFF, '0, -16'sd4096, '0, '0, '0));
      add_row(tick_row(1'b1, 32'd90, 16'hFFFF, '0, -16'sd4097, '0, '0, '0));
      add_row(tick_row(1'b1, 32'd100, 16'd411, '0, '0, '0, '0, '0));
      add_row(tick_row(1'b1, 32'd110, '0, '0, '0, '0, '0, '0));
      // Thresholds at their top and bottom ends.
      add_row(reg_row(CSR_STANCE_LOAD_MIN, 48'hFFFF));
      add_row(reg_row(CSR_SWING_LOAD_MAX, 48'hFFFF));
      add_row(reg_row(CSR_LANDING_RATIO, 48'h7FFF));
      add_row(reg_row(CSR_LATE_STANCE_RATIO, 48'h8000));
      add_row(reg_row(CSR_LIFTOFF_RATIO, 48'h8000));
      add_row(reg_row(CSR_LEG_LEN, 48'hFFFF));
      add_row(tick_row(1'b1, 32'd120, 16'hFFFF, 16'hFFFF,
                       16'sd32767, 16'sh8000, 16'sh8000, 16'sd32767));
      add_row(tick_row(1'b0, 32'd130, '0, '0, '0, '0, '0, '0));
      add_row(reg_row(CSR_STANCE_LOAD_MIN, 48'h0));
      add_row(reg_row(CSR_SWING_LOAD_MAX, 48'h0));
      add_row(reg_row(CSR_LANDING_RATIO, 48'h0));
      add_row(reg_row(CSR_LATE_STANCE_RATIO, 48'h0));
      add_row(reg_row(CSR_LIFTOFF_RATIO, 48'h0));
      add_row(reg_row(CSR_LEG_LEN, 48'h0));
      add_row(tick_row(1'b1, 32'd140, 16'd1, 16'd1, 16'sd1, '0, '0, 16'sd1));
      add_row(tick_row(1'b1, 32'd150, '0, '0, '0, '0, '0, '0));
      add_row(tick_row(1'b0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                       -16'sd1, -16'sd1, -16'sd1, -16'sd1));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed plan: register rows wait for the block to drain first.
      foreach (plan[i]) begin
         if (plan[i].csr) begin
            wait_for_quiet();
            write_reg(plan[i].idx, plan[i].data);
         end else begin
            send_tick(plan[i]);
         end
      end

      // Random phases: fresh registers, then mostly walking strides with noise mixed in.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_for_quiet();
         write_reg(CSR_STANCE_LOAD_MIN, 48'(pick_load_level()));
         write_reg(CSR_SWING_LOAD_MAX, 48'(pick_load_level()));
         write_reg(CSR_LANDING_RATIO, 48'(pick_ratio()));
         write_reg(CSR_LATE_STANCE_RATIO, 48'(pick_ratio()));
         write_reg(CSR_LIFTOFF_RATIO, 48'(pick_ratio()));
         write_reg(CSR_LEG_LEN, ($urandom_range(0, 4) == 0) ?
                                48'($urandom_range(0, 65535)) :
                                48'($urandom_range(2048, 8192)));
         write_reg(CSR_SLOT_PHASE_MASKS, 48'({$urandom, $urandom}));
         write_reg(CSR_SLOT_LEG_SELECT, 48'($urandom_range(0, 255)));
         period = 2 * $urandom_range(3, 8);
         half = period / 2;
         amp = $urandom_range(800, 12000);
         g = $urandom_range(0, period - 1);
         now_t = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF80 : $urandom;
         for (int n = 0; n < TICKS_PER_PHASE; n++) begin
            now_t += $urandom_range(0, 40);
            if ($urandom_range(0, 3) != 0) begin
               // Left leg loaded in the first half of the stride, right in the second.
               place_leg(stride_offset(g, half, amp), lf, lb);
               place_leg(stride_offset((g + half) % period, half, amp), rf, rb);
               send_tick(tick_row($urandom_range(0, 9) != 0, now_t,
                                  load_for(g < half), load_for(g >= half),
                                  lf, lb, rf, rb));
               g = (g + 1) % period;
            end else begin
               send_tick(tick_row($urandom_range(0, 1) != 0,
                                  ($urandom_range(0, 1) != 0) ? $urandom : now_t,
                                  16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom), 16'($urandom), 16'($urandom)));
            end
         end
      end

      wait_for_quiet();
      repeat (12) @(posedge clock);
      if (error_count == 0 && slot_reports_due.size() == 0) begin
         $display("tb_gait_phase_detector: done, clean");
      end else begin
         $display("tb_gait_phase_detector: done, errors");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+hdl
hdl/gpd_pkg.sv
hdl/gpd_fifo.sv
hdl/gpd_front.sv
hdl/gpd_back.sv
hdl/gait_phase_detector.sv
hdl/gpd_checker.sv
bench/tb_gait_phase_detector.sv
